// ----- rtl/quaternion_attitude_filter_unit_assert.svh -----
// Assertion macros shared by the attitude filter RTL.
`ifndef QUATERNION_ATTITUDE_FILTER_UNIT_ASSERT_SVH
`define QUATERNION_ATTITUDE_FILTER_UNIT_ASSERT_SVH
`ifndef ASSERT_OFF
`define QAF_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("qaf assertion failed");
`define QAF_ASSERT_NXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("qaf assertion failed");
`else
`define QAF_ASSERT_IMP(lbl, clk, rstn, ante, cons)
`define QAF_ASSERT_NXT(lbl, clk, rstn, ante, cons)
`endif
`endif

// ----- rtl/qaf_pkg.sv -----
// Types, constants and helper functions of the quaternion attitude filter.
package qaf_pkg;

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_RUN  = 4'b0010,
        S_NORM = 4'b0100,
        S_DONE = 4'b1000
    } t_state;

    // Configuration register indexes.
    localparam logic [2:0] REG_ACC_OFS_X  = 3'd0;
    localparam logic [2:0] REG_ACC_OFS_Y  = 3'd1;
    localparam logic [2:0] REG_ACC_OFS_Z  = 3'd2;
    localparam logic [2:0] REG_GYRO_OFS_X = 3'd3;
    localparam logic [2:0] REG_GYRO_OFS_Y = 3'd4;
    localparam logic [2:0] REG_GYRO_OFS_Z = 3'd5;
    localparam logic [2:0] REG_PROP_GAIN  = 3'd6;
    localparam logic [2:0] REG_INTEG_GAIN = 3'd7;

    // Sequencer program entry points.
    localparam logic [5:0] SQ_SUMA = 6'd0;   // accel sum of squares, 4 steps
    localparam logic [5:0] SQ_ISQ  = 6'd4;   // inverse square root, 7 steps
    localparam logic [5:0] SQ_NA   = 6'd11;  // accel scaling, 4 steps
    localparam logic [5:0] SQ_V    = 6'd15;  // gravity direction, 9 steps
    localparam logic [5:0] SQ_E    = 6'd24;  // cross product error, 7 steps
    localparam logic [5:0] SQ_G    = 6'd31;  // PI correction per axis, 6 steps
    localparam logic [5:0] SQ_Q    = 6'd37;  // quaternion advance, 13 steps
    localparam logic [5:0] SQ_SUMQ = 6'd50;  // quaternion sum of squares, 5 steps
    localparam logic [5:0] SQ_NQ   = 6'd55;  // quaternion scaling, 5 steps

    localparam logic [4:0]         HH_START   = 5'd15;
    localparam logic signed [35:0] GYRO_SCALE = 36'sd285615;
    localparam logic signed [31:0] ONE_Q30    = 32'sd1073741824;
    localparam logic [31:0]        SEED_MAGIC = 32'h5F3759DF;
    localparam logic signed [33:0] THREE_HALF = 34'sd1610612736;

    function automatic logic [29:0] isr_seed(input logic [31:0] t);
        logic        b;
        logic [31:0] bits;
        logic [31:0] r;
        logic [8:0]  ex;
        logic [23:0] mant;
        logic [2:0]  sh;
        b    = t[31];
        bits = {1'b0, 8'd127 + {7'd0, b}, (b ? t[30:8] : t[29:7])};
        r    = SEED_MAGIC - {1'b0, bits[31:1]};
        ex   = r[31:23];
        if (ex < 9'd120) begin
            sh = 3'd0;
        end else if (ex > 9'd126) begin
            sh = 3'd6;
        end else begin
            sh = 3'(ex - 9'd120);
        end
        mant = {1'b1, r[22:0]};
        return 30'({6'd0, mant} << sh);
    endfunction

    function automatic logic signed [31:0] sat32(input logic signed [75:0] v);
        if (v > 76'sd2147483647) begin
            return 32'sh7FFFFFFF;
        end else if (v < -76'sd2147483648) begin
            return 32'sh80000000;
        end
        return v[31:0];
    endfunction

    function automatic logic signed [31:0] sat_sym(input logic signed [75:0] v);
        if (v > 76'sd2147483647) begin
            return 32'sh7FFFFFFF;
        end else if (v < -76'sd2147483647) begin
            return -32'sh7FFFFFFF;
        end
        return v[31:0];
    endfunction

    function automatic logic signed [31:0] sat_q30(input logic signed [75:0] v);
        if (v > 76'sd1073741824) begin
            return ONE_Q30;
        end else if (v < -76'sd1073741824) begin
            return -ONE_Q30;
        end
        return v[31:0];
    endfunction

endpackage

// ----- rtl/quaternion_attitude_filter_unit.sv -----
// Quaternion attitude filter: six-axis sample in, updated attitude out.
//
// Input channel: i_in_valid with the six raw counts; the block raises o_in_stall
// from the transfer until the result has moved into the output register.
// Output channel: o_out_valid with the four Q2.30 components; the receiver holds
// i_out_stall high to keep the result waiting in the output register.
// A new input is taken only after the result has moved to the output register and
// the block is back in idle. All products go through one shared 36x36 multiplier
// under a step sequencer; the two inverse square roots add a normalizing loop of
// one 2-bit shift per cycle each, and a zero acceleration skips the first one.
// A new item is taken while the previous result still waits; the sequencer
// then holds its finished result until the output register is free.
// Configuration writes go through i_cfg_we, i_cfg_index and i_cfg_data; the user
// must make them only while the block is idle, as the block does not enforce it.
// Reset (synchronous, active low) sets the attitude to the unit quaternion,
// clears the error integral, restores register defaults and empties the
// output register.
module quaternion_attitude_filter_unit
    import qaf_pkg::*;
#(
    parameter int HALF_PERIOD_Q30 = 2684355
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_we,
    input  logic [2:0]         i_cfg_index,
    input  logic [24:0]        i_cfg_data,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  logic signed [15:0] i_accel_x,
    input  logic signed [15:0] i_accel_y,
    input  logic signed [15:0] i_accel_z,
    input  logic signed [15:0] i_rate_x,
    input  logic signed [15:0] i_rate_y,
    input  logic signed [15:0] i_rate_z,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output logic signed [31:0] o_quat_w,
    output logic signed [31:0] o_quat_x,
    output logic signed [31:0] o_quat_y,
    output logic signed [31:0] o_quat_z
);

`include "quaternion_attitude_filter_unit_assert.svh"

    localparam logic signed [35:0] HALF_T = 36'(HALF_PERIOD_Q30);

    // Configuration registers.
    logic signed [15:0] r_aox, r_aoy, r_gox, r_goy, r_goz;
    logic signed [16:0] r_aoz;
    logic [23:0]        r_kp;
    logic [24:0]        r_ki;

    t_state             r_state, n_state;
    logic [5:0]         r_step, n_step;
    logic [1:0]         r_axis, n_axis;
    logic               r_pass, n_pass;
    logic signed [75:0] r_acc, n_acc;
    logic signed [71:0] r_prod;
    logic signed [35:0] r_a [3], n_a [3];
    logic signed [17:0] r_gd [3], n_gd [3];
    logic signed [35:0] r_v [3], n_v [3];
    logic signed [35:0] r_e [3], n_e [3];
    logic signed [31:0] r_ei [3], n_ei [3];
    logic signed [31:0] r_w [3], n_w [3];
    logic signed [31:0] r_q [4], n_q [4];
    logic signed [31:0] r_n [4], n_n [4];
    logic signed [31:0] r_out [4], n_out [4];
    logic signed [31:0] r_g, n_g;
    logic               r_out_valid, n_out_valid;
    logic [63:0]        r_t, n_t;
    logic [4:0]         r_hh, n_hh;
    logic [29:0]        r_y, n_y;
    logic [29:0]        r_yy, n_yy;
    logic [30:0]        r_f, n_f;
    logic [30:0]        r_isr, n_isr;

    logic signed [35:0] mul_a, mul_b;
    logic signed [71:0] mul_p;
    logic signed [75:0] prod_ext, acc_add, acc_sub, prod_sh, p30;
    logic signed [33:0] f_raw;
    logic signed [17:0] d_ax, d_ay, d_az, d_gx, d_gy, d_gz;

    assign mul_p    = mul_a * mul_b;
    assign prod_ext = 76'(r_prod);
    assign acc_add  = r_acc + prod_ext;
    assign acc_sub  = r_acc - prod_ext;
    assign prod_sh  = prod_ext >>> r_hh;
    assign p30      = prod_ext >>> 30;
    assign f_raw    = THREE_HALF - 34'(r_prod[61:31]);

    assign d_ax = 18'(i_accel_x) - 18'(r_aox);
    assign d_ay = 18'(i_accel_y) - 18'(r_aoy);
    assign d_az = 18'(i_accel_z) - 18'(r_aoz);
    assign d_gx = 18'(i_rate_x) - 18'(r_gox);
    assign d_gy = 18'(i_rate_y) - 18'(r_goy);
    assign d_gz = 18'(i_rate_z) - 18'(r_goz);

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_quat_w    = r_out[0];
    assign o_quat_x    = r_out[1];
    assign o_quat_y    = r_out[2];
    assign o_quat_z    = r_out[3];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_aox <= '0;
            r_aoy <= '0;
            r_aoz <= -17'sd20070;
            r_gox <= '0;
            r_goy <= '0;
            r_goz <= '0;
            r_kp  <= 24'd1310720;
            r_ki  <= 25'd16777;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                REG_ACC_OFS_X:  r_aox <= i_cfg_data[15:0];
                REG_ACC_OFS_Y:  r_aoy <= i_cfg_data[15:0];
                REG_ACC_OFS_Z:  r_aoz <= i_cfg_data[16:0];
                REG_GYRO_OFS_X: r_gox <= i_cfg_data[15:0];
                REG_GYRO_OFS_Y: r_goy <= i_cfg_data[15:0];
                REG_GYRO_OFS_Z: r_goz <= i_cfg_data[15:0];
                REG_PROP_GAIN:  r_kp  <= i_cfg_data[23:0];
                REG_INTEG_GAIN: r_ki  <= i_cfg_data;
                default: ;
            endcase
        end
    end

    always_comb begin
        n_state     = r_state;
        n_step      = r_step;
        n_axis      = r_axis;
        n_pass      = r_pass;
        n_acc       = r_acc;
        n_a         = r_a;
        n_gd        = r_gd;
        n_v         = r_v;
        n_e         = r_e;
        n_ei        = r_ei;
        n_w         = r_w;
        n_q         = r_q;
        n_n         = r_n;
        n_out       = r_out;
        n_g         = r_g;
        n_t         = r_t;
        n_hh        = r_hh;
        n_y         = r_y;
        n_yy        = r_yy;
        n_f         = r_f;
        n_isr       = r_isr;
        n_out_valid = r_out_valid && i_out_stall;
        mul_a       = '0;
        mul_b       = '0;

        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_a[0]  = 36'(d_ax);
                    n_a[1]  = 36'(d_ay);
                    n_a[2]  = 36'(d_az);
                    n_gd[0] = d_gx;
                    n_gd[1] = d_gy;
                    n_gd[2] = d_gz;
                    n_step  = SQ_SUMA;
                    n_axis  = 2'd0;
                    n_state = S_RUN;
                end
            end

            S_NORM: begin
                // Bring the sum into [1,4) in Q2.30, two bits per cycle.
                if (r_t[63:32] != 32'd0) begin
                    n_t  = r_t >> 2;
                    n_hh = r_hh + 5'd1;
                end else if (r_t[31:30] == 2'd0) begin
                    n_t  = r_t << 2;
                    n_hh = r_hh - 5'd1;
                end else begin
                    n_step  = SQ_ISQ;
                    n_state = S_RUN;
                end
            end

            S_DONE: begin
                if (!r_out_valid || !i_out_stall) begin
                    n_out       = r_q;
                    n_out_valid = 1'b1;
                    n_state     = S_IDLE;
                end
            end

            S_RUN: begin
                n_step = r_step + 6'd1;
                unique case (r_step)
                    // Sum of squares of the corrected acceleration.
                    SQ_SUMA: begin
                        mul_a = r_a[0]; mul_b = r_a[0];
                    end
                    SQ_SUMA + 6'd1: begin
                        n_acc = prod_ext; mul_a = r_a[1]; mul_b = r_a[1];
                    end
                    SQ_SUMA + 6'd2: begin
                        n_acc = acc_add; mul_a = r_a[2]; mul_b = r_a[2];
                    end
                    SQ_SUMA + 6'd3: begin
                        // Zero acceleration skips the scaling; the error is then zero.
                        if (acc_add == '0) begin
                            n_step = SQ_V;
                        end else begin
                            n_t     = acc_add[63:0];
                            n_hh    = HH_START;
                            n_pass  = 1'b0;
                            n_state = S_NORM;
                        end
                    end

                    // Inverse square root: seed and one Newton step.
                    SQ_ISQ: begin
                        n_y = isr_seed(r_t[31:0]);
                    end
                    SQ_ISQ + 6'd1: begin
                        mul_a = 36'(r_y); mul_b = 36'(r_y);
                    end
                    SQ_ISQ + 6'd2: begin
                        n_yy = r_prod[59:30];
                    end
                    SQ_ISQ + 6'd3: begin
                        mul_a = 36'(r_t[31:0]); mul_b = 36'(r_yy);
                    end
                    SQ_ISQ + 6'd4: begin
                        n_f = f_raw[33] ? 31'd0 : f_raw[30:0];
                    end
                    SQ_ISQ + 6'd5: begin
                        mul_a = 36'(r_y); mul_b = 36'(r_f);
                    end
                    SQ_ISQ + 6'd6: begin
                        n_isr  = r_prod[60:30];
                        n_step = r_pass ? SQ_NQ : SQ_NA;
                    end

                    SQ_NA: begin
                        mul_a = r_a[0]; mul_b = 36'(r_isr);
                    end
                    SQ_NA + 6'd1: begin
                        n_a[0] = prod_sh[35:0]; mul_a = r_a[1]; mul_b = 36'(r_isr);
                    end
                    SQ_NA + 6'd2: begin
                        n_a[1] = prod_sh[35:0]; mul_a = r_a[2]; mul_b = 36'(r_isr);
                    end
                    SQ_NA + 6'd3: begin
                        n_a[2] = prod_sh[35:0];
                    end

                    // Gravity direction predicted by the attitude.
                    SQ_V: begin
                        mul_a = 36'(r_q[1]); mul_b = 36'(r_q[3]);
                    end
                    SQ_V + 6'd1: begin
                        n_acc = prod_ext; mul_a = 36'(r_q[0]); mul_b = 36'(r_q[2]);
                    end
                    SQ_V + 6'd2: begin
                        n_v[0] = 36'(acc_sub >>> 29);
                        mul_a = 36'(r_q[2]); mul_b = 36'(r_q[3]);
                    end
                    SQ_V + 6'd3: begin
                        n_acc = prod_ext; mul_a = 36'(r_q[0]); mul_b = 36'(r_q[1]);
                    end
                    SQ_V + 6'd4: begin
                        n_v[1] = 36'(acc_add >>> 29);
                        mul_a = 36'(r_q[0]); mul_b = 36'(r_q[0]);
                    end
                    SQ_V + 6'd5: begin
                        n_acc = prod_ext; mul_a = 36'(r_q[1]); mul_b = 36'(r_q[1]);
                    end
                    SQ_V + 6'd6: begin
                        n_acc = acc_sub; mul_a = 36'(r_q[2]); mul_b = 36'(r_q[2]);
                    end
                    SQ_V + 6'd7: begin
                        n_acc = acc_sub; mul_a = 36'(r_q[3]); mul_b = 36'(r_q[3]);
                    end
                    SQ_V + 6'd8: begin
                        n_v[2] = 36'(acc_add >>> 30);
                    end

                    // Cross product; each term is truncated before the difference.
                    SQ_E: begin
                        mul_a = r_a[1]; mul_b = r_v[2];
                    end
                    SQ_E + 6'd1: begin
                        n_acc = p30; mul_a = r_a[2]; mul_b = r_v[1];
                    end
                    SQ_E + 6'd2: begin
                        n_e[0] = 36'(r_acc - p30); mul_a = r_a[2]; mul_b = r_v[0];
                    end
                    SQ_E + 6'd3: begin
                        n_acc = p30; mul_a = r_a[0]; mul_b = r_v[2];
                    end
                    SQ_E + 6'd4: begin
                        n_e[1] = 36'(r_acc - p30); mul_a = r_a[0]; mul_b = r_v[1];
                    end
                    SQ_E + 6'd5: begin
                        n_acc = p30; mul_a = r_a[1]; mul_b = r_v[0];
                    end
                    SQ_E + 6'd6: begin
                        n_e[2] = 36'(r_acc - p30);
                    end

                    // Integral and corrected rate, one axis per pass.
                    SQ_G: begin
                        mul_a = 36'(r_ki); mul_b = r_e[r_axis];
                    end
                    SQ_G + 6'd1: begin
                        n_ei[r_axis] = sat32(76'(r_ei[r_axis]) + (prod_ext >>> 26));
                        mul_a = 36'(r_gd[r_axis]); mul_b = GYRO_SCALE;
                    end
                    SQ_G + 6'd2: begin
                        n_acc = prod_ext + 76'(r_ei[r_axis]);
                        mul_a = 36'(r_kp); mul_b = r_e[r_axis];
                    end
                    SQ_G + 6'd3: begin
                        n_g = sat32(r_acc + (prod_ext >>> 18));
                    end
                    SQ_G + 6'd4: begin
                        mul_a = 36'(r_g); mul_b = HALF_T;
                    end
                    SQ_G + 6'd5: begin
                        n_w[r_axis] = p30[31:0];
                        if (r_axis == 2'd2) begin
                            n_axis = 2'd0;
                        end else begin
                            n_axis = r_axis + 2'd1;
                            n_step = SQ_G;
                        end
                    end

                    // Quaternion advance from the previous components.
                    SQ_Q: begin
                        mul_a = 36'(r_q[1]); mul_b = 36'(r_w[0]);
                    end
                    SQ_Q + 6'd1: begin
                        n_acc = -prod_ext; mul_a = 36'(r_q[2]); mul_b = 36'(r_w[1]);
                    end
                    SQ_Q + 6'd2: begin
                        n_acc = acc_sub; mul_a = 36'(r_q[3]); mul_b = 36'(r_w[2]);
                    end
                    SQ_Q + 6'd3: begin
                        n_n[0] = sat_sym(76'(r_q[0]) + (acc_sub >>> 28));
                        mul_a = 36'(r_q[0]); mul_b = 36'(r_w[0]);
                    end
                    SQ_Q + 6'd4: begin
                        n_acc = prod_ext; mul_a = 36'(r_q[2]); mul_b = 36'(r_w[2]);
                    end
                    SQ_Q + 6'd5: begin
                        n_acc = acc_add; mul_a = 36'(r_q[3]); mul_b = 36'(r_w[1]);
                    end
                    SQ_Q + 6'd6: begin
                        n_n[1] = sat_sym(76'(r_q[1]) + (acc_sub >>> 28));
                        mul_a = 36'(r_q[0]); mul_b = 36'(r_w[1]);
                    end
                    SQ_Q + 6'd7: begin
                        n_acc = prod_ext; mul_a = 36'(r_q[1]); mul_b = 36'(r_w[2]);
                    end
                    SQ_Q + 6'd8: begin
                        n_acc = acc_sub; mul_a = 36'(r_q[3]); mul_b = 36'(r_w[0]);
                    end
                    SQ_Q + 6'd9: begin
                        n_n[2] = sat_sym(76'(r_q[2]) + (acc_add >>> 28));
                        mul_a = 36'(r_q[0]); mul_b = 36'(r_w[2]);
                    end
                    SQ_Q + 6'd10: begin
                        n_acc = prod_ext; mul_a = 36'(r_q[1]); mul_b = 36'(r_w[1]);
                    end
                    SQ_Q + 6'd11: begin
                        n_acc = acc_add; mul_a = 36'(r_q[2]); mul_b = 36'(r_w[0]);
                    end
                    SQ_Q + 6'd12: begin
                        n_n[3] = sat_sym(76'(r_q[3]) + (acc_sub >>> 28));
                    end

                    SQ_SUMQ: begin
                        mul_a = 36'(r_n[0]); mul_b = 36'(r_n[0]);
                    end
                    SQ_SUMQ + 6'd1: begin
                        n_acc = prod_ext; mul_a = 36'(r_n[1]); mul_b = 36'(r_n[1]);
                    end
                    SQ_SUMQ + 6'd2: begin
                        n_acc = acc_add; mul_a = 36'(r_n[2]); mul_b = 36'(r_n[2]);
                    end
                    SQ_SUMQ + 6'd3: begin
                        n_acc = acc_add; mul_a = 36'(r_n[3]); mul_b = 36'(r_n[3]);
                    end
                    SQ_SUMQ + 6'd4: begin
                        // An all-zero quaternion falls back to the identity.
                        if (acc_add == '0) begin
                            n_q[0]  = ONE_Q30;
                            n_q[1]  = '0;
                            n_q[2]  = '0;
                            n_q[3]  = '0;
                            n_state = S_DONE;
                        end else begin
                            n_t     = acc_add[63:0];
                            n_hh    = HH_START;
                            n_pass  = 1'b1;
                            n_state = S_NORM;
                        end
                    end

                    SQ_NQ: begin
                        mul_a = 36'(r_n[0]); mul_b = 36'(r_isr);
                    end
                    SQ_NQ + 6'd1: begin
                        n_q[0] = sat_q30(prod_sh); mul_a = 36'(r_n[1]); mul_b = 36'(r_isr);
                    end
                    SQ_NQ + 6'd2: begin
                        n_q[1] = sat_q30(prod_sh); mul_a = 36'(r_n[2]); mul_b = 36'(r_isr);
                    end
                    SQ_NQ + 6'd3: begin
                        n_q[2] = sat_q30(prod_sh); mul_a = 36'(r_n[3]); mul_b = 36'(r_isr);
                    end
                    SQ_NQ + 6'd4: begin
                        n_q[3]  = sat_q30(prod_sh);
                        n_state = S_DONE;
                    end

                    default: begin
                        n_state = S_IDLE;
                    end
                endcase
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
            r_step      <= SQ_SUMA;
            r_axis      <= 2'd0;
            r_pass      <= 1'b0;
            r_q[0]      <= ONE_Q30;
            r_q[1]      <= '0;
            r_q[2]      <= '0;
            r_q[3]      <= '0;
            r_ei[0]     <= '0;
            r_ei[1]     <= '0;
            r_ei[2]     <= '0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
            r_step      <= n_step;
            r_axis      <= n_axis;
            r_pass      <= n_pass;
            r_q         <= n_q;
            r_ei        <= n_ei;
        end
    end

    always_ff @(posedge i_clk) begin
        r_prod <= mul_p;
        r_acc  <= n_acc;
        r_a    <= n_a;
        r_gd   <= n_gd;
        r_v    <= n_v;
        r_e    <= n_e;
        r_w    <= n_w;
        r_n    <= n_n;
        r_out  <= n_out;
        r_g    <= n_g;
        r_t    <= n_t;
        r_hh   <= n_hh;
        r_y    <= n_y;
        r_yy   <= n_yy;
        r_f    <= n_f;
        r_isr  <= n_isr;
    end

    // The attitude only moves while an update is in progress.
    `QAF_ASSERT_NXT(a_att_hold_idle, i_clk, i_rst_n, r_state == S_IDLE,
        $stable(r_q[0]) && $stable(r_q[1]) && $stable(r_q[2]) && $stable(r_q[3]))
    // The normalizing loop hands over a value in [1,4) in Q2.30.
    `QAF_ASSERT_IMP(a_isr_range, i_clk, i_rst_n, r_state == S_RUN && r_step == SQ_ISQ,
        r_t[63:32] == 32'd0 && r_t[31:30] != 2'd0)
    // A new result appears only out of the finishing state.
    `QAF_ASSERT_NXT(a_out_from_done, i_clk, i_rst_n, !r_out_valid,
        !r_out_valid || $past(r_state == S_DONE))
    // The first and last delivered components lie within plus or minus one.
    `QAF_ASSERT_IMP(a_out_bound, i_clk, i_rst_n, r_out_valid,
        r_out[0] <= ONE_Q30 && r_out[0] >= -ONE_Q30 &&
        r_out[3] <= ONE_Q30 && r_out[3] >= -ONE_Q30)

endmodule
